// File: rtl/ucidf_pkg.sv
// ----------------------------------------------------------------------------
// UCI packet deframer package
// Header field masks, type codes and the result record shared by the
// parser, the result register and the top level.
// ----------------------------------------------------------------------------
package ucidf_pkg;

    // Header byte 0 masks
    localparam logic [7:0] TYPE_MASK     = 8'hE0;
    localparam logic [7:0] GROUP_MASK    = 8'h0F;
    localparam logic [7:0] BOUNDARY_MASK = 8'h10;

    // Message type codes
    localparam logic [2:0] DATA_TYPE         = 3'd0;
    localparam logic [2:0] NOTIFICATION_TYPE = 3'd3;

    // Header bytes held before the last one arrives
    localparam int unsigned WIN_DEPTH = 3;

    // Accepted header fields
    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  opcode_id;
        logic [3:0]  group_id;
        logic        boundary_flag;
        logic [1:0]  msg_type;
    } hdr_t;

    // One result item
    typedef struct packed {
        logic       packet_last;
        logic [7:0] payload_byte;
        logic       has_byte;
        hdr_t       hdr;
    } result_t;

endpackage

// File: rtl/uci_packet_deframer.sv
// ----------------------------------------------------------------------------
// UCI packet deframer
// Splits a received byte stream into UCI packets and streams each payload
// byte out with its header fields.
// ----------------------------------------------------------------------------
// One received byte is taken per clock while m_tready stays high. Each byte
// passes an input register, the header and payload-count logic, and a result
// register, from which its result is presented; header bytes and dropped
// bytes give no result. A header whose type field exceeds
// notification slides the header window by one byte to resynchronize.
// A packet with an empty payload gives a single result with has_byte low.
// Throughput is one byte per cycle while m_tready stays high.
module uci_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] boundary_flag, [4:1] group_id, [12:5] opcode_id,
    // [28:13] payload_length, [36:29] payload_byte, [39:37] zero
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser,   // [1:0] msg_type, [2] has_byte
    output logic        m_tlast    // packet_last
);

    import ucidf_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       step;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    ucidf_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_byte     (s_tdata),
        .step       (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ucidf_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    ucidf_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .res_valid  (res_valid),
        .res        (res),
        .step       (step),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (m_res)
    );

    // Pack the result fields
    assign m_tdata = {3'b000, m_res.payload_byte, m_res.hdr.payload_length,
                      m_res.hdr.opcode_id, m_res.hdr.group_id,
                      m_res.hdr.boundary_flag};
    assign m_tuser = {m_res.has_byte, m_res.hdr.msg_type};
    assign m_tlast = m_res.packet_last;

    // A result without a byte is an empty packet: last, zero length, zero byte
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[2]) |-> (m_tlast && m_tdata[28:13] == 16'd0))
        else $error("empty result not a complete zero-length packet");

    a_empty_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[2]) |-> (m_tdata[36:29] == 8'h00))
        else $error("payload byte nonzero without has_byte");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// File: rtl/ucidf_in_reg.sv
// ----------------------------------------------------------------------------
// UCI deframer input register
// Holds one received byte until the parser consumes it; refills in the
// same cycle so a byte can enter on every clock that the parser consumes one.
// ----------------------------------------------------------------------------
module ucidf_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_byte,
    input  logic       step,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    // Take a new request when empty or when the held byte leaves now
    assign s_tready = ~valid_reg | step;
    assign load     = s_tvalid & s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (step) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// File: rtl/ucidf_parser.sv
// ----------------------------------------------------------------------------
// UCI deframer parser
// Collects header bytes in a sliding window, checks the message type,
// latches the header and counts payload bytes. Produces at most one
// result per consumed byte.
// ----------------------------------------------------------------------------
module ucidf_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          byte_data,
    output logic                res_valid,
    output ucidf_pkg::result_t  res
);

    import ucidf_pkg::*;

    logic [7:0]  win_reg [WIN_DEPTH];
    logic [7:0]  win_next [WIN_DEPTH];
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        in_payload_reg;
    logic        in_payload_next;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    hdr_t        latched_reg;
    hdr_t        latched_next;

    logic [7:0]  type_bits;
    logic [2:0]  type_raw;
    logic [15:0] len;
    logic [15:0] rem_dec;
    hdr_t        hdr_new;

    // Decode the oldest header byte
    assign type_bits = win_reg[0] & TYPE_MASK;
    assign type_raw  = type_bits[7:5];
    assign len       = (type_raw == DATA_TYPE) ? {byte_data, win_reg[2]}
                                               : {8'h00, byte_data};
    assign rem_dec   = remaining_reg - 16'd1;

    always_comb begin
        logic [7:0] bnd_bits;
        logic [7:0] grp_bits;
        bnd_bits               = win_reg[0] & BOUNDARY_MASK;
        grp_bits               = win_reg[0] & GROUP_MASK;
        hdr_new.msg_type       = type_raw[1:0];
        hdr_new.boundary_flag  = bnd_bits[4];
        hdr_new.group_id       = grp_bits[3:0];
        hdr_new.opcode_id      = win_reg[1];
        hdr_new.payload_length = len;
    end

    // Next state and result
    always_comb begin
        win_next        = win_reg;
        fill_next       = fill_reg;
        in_payload_next = in_payload_reg;
        remaining_next  = remaining_reg;
        latched_next    = latched_reg;
        res_valid       = 1'b0;
        res.hdr         = latched_reg;
        res.has_byte    = 1'b1;
        res.payload_byte = byte_data;
        res.packet_last = 1'b0;

        if (in_payload_reg) begin
            // Stream a payload byte, flag the final one
            remaining_next  = rem_dec;
            in_payload_next = (rem_dec != 16'd0);
            res_valid       = 1'b1;
            res.packet_last = (rem_dec == 16'd0);
        end else if (fill_reg != 2'd3) begin
            // Collect a header byte
            case (fill_reg)
                2'd0:    win_next[0] = byte_data;
                2'd1:    win_next[1] = byte_data;
                default: win_next[2] = byte_data;
            endcase
            fill_next = fill_reg + 2'd1;
        end else if (type_raw > NOTIFICATION_TYPE) begin
            // Bad type: drop the oldest byte and slide the window
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = byte_data;
        end else begin
            // Accept the header
            latched_next = hdr_new;
            fill_next    = 2'd0;
            if (len == 16'd0) begin
                res_valid        = 1'b1;
                res.hdr          = hdr_new;
                res.has_byte     = 1'b0;
                res.payload_byte = 8'h00;
                res.packet_last  = 1'b1;
            end else begin
                in_payload_next = 1'b1;
                remaining_next  = len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= 2'd0;
            in_payload_reg <= 1'b0;
            remaining_reg  <= 16'd0;
            latched_reg    <= '0;
        end else if (step) begin
            fill_reg       <= fill_next;
            in_payload_reg <= in_payload_next;
            remaining_reg  <= remaining_next;
            latched_reg    <= latched_next;
        end
    end

    // Header window payload
    always_ff @(posedge aclk) begin
        if (step) begin
            win_reg <= win_next;
        end
    end

endmodule

// File: rtl/ucidf_out_reg.sv
// ----------------------------------------------------------------------------
// UCI deframer result register
// Holds one result for the downstream side; frees itself in the cycle it
// is taken so the parser never stalls on a ready sink.
// ----------------------------------------------------------------------------
module ucidf_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_valid,
    input  logic                res_valid,
    input  ucidf_pkg::result_t  res,
    output logic                step,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ucidf_pkg::result_t  m_res
);

    import ucidf_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    free;

    // Consume a byte when the result slot is empty or being taken
    assign free = ~valid_reg | m_tready;
    assign step = byte_valid & free;

    always_comb begin
        valid_next = valid_reg;
        if (step) begin
            valid_next = res_valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule
